// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on clk_i, disabled in reset
`define ART_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication on clk_i, disabled in reset
`define ART_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/art_pkg.sv =====
package art_pkg;

  localparam int unsigned MaxRegions = 64;
  localparam int unsigned PageBytes  = 4096;

  localparam logic [1:0] FUNC_MAP   = 2'd0;
  localparam logic [1:0] FUNC_FIND  = 2'd1;
  localparam logic [1:0] FUNC_CHECK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic REG_USER_BASE = 1'b0;
  localparam logic REG_USER_TOP  = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] addr;
    logic [31:0] length;
    logic [3:0]  flags;
    logic        write_access;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [3:0]  region_flags;
    logic        access_ok;
  } out_t;

  typedef enum logic [2:0] {
    RS_INVALID,
    RS_FULL,
    RS_MAPPED,
    RS_FOUND,
    RS_NOTFOUND,
    RS_GRANT,
    RS_DENY
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     scan_start;
    logic     scan_run;
    logic     capture;
    logic     advance;
    logic     commit;
    logic     out_load;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       win_ok;
    logic       ent_v;
    logic       ent_last;
    logic       hit;
    logic       ovl;
    logic       perm_ok;
    logic       end_reach;
    logic       full;
    logic       out_free;
  } sts_t;

endpackage

// ===== hdl/art_ctrl.sv =====
module art_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  art_pkg::sts_t sts_i,
  output art_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MAP,
    S_COMMIT,
    S_FIND,
    S_CHECK,
    S_DONE
  } state_e;

  state_e              state_q, state_d;
  art_pkg::res_sel_e   res_q, res_d;

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_sel = res_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.scan_start = 1'b1;
        case (sts_i.func)
          art_pkg::FUNC_MAP: begin
            if (sts_i.win_ok) begin
              state_d = S_MAP;
            end else begin
              res_d = art_pkg::RS_INVALID;
              state_d = S_DONE;
            end
          end
          art_pkg::FUNC_FIND: begin
            state_d = S_FIND;
          end
          art_pkg::FUNC_CHECK: begin
            if (sts_i.win_ok) begin
              state_d = S_CHECK;
            end else begin
              res_d = art_pkg::RS_DENY;
              state_d = S_DONE;
            end
          end
          default: begin
            res_d = art_pkg::RS_INVALID;
            state_d = S_DONE;
          end
        endcase
      end
      S_MAP: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.ent_v) begin
          if (sts_i.ovl) begin
            res_d = art_pkg::RS_INVALID;
            state_d = S_DONE;
          end else if (sts_i.ent_last) begin
            state_d = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        if (sts_i.full) begin
          res_d = art_pkg::RS_FULL;
        end else begin
          cmd_o.commit = 1'b1;
          res_d = art_pkg::RS_MAPPED;
        end
        state_d = S_DONE;
      end
      S_FIND: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.ent_v) begin
          if (sts_i.hit) begin
            cmd_o.capture = 1'b1;
            res_d = art_pkg::RS_FOUND;
            state_d = S_DONE;
          end else if (sts_i.ent_last) begin
            res_d = art_pkg::RS_NOTFOUND;
            state_d = S_DONE;
          end
        end
      end
      S_CHECK: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.ent_v) begin
          if (sts_i.hit) begin
            if (!sts_i.perm_ok) begin
              res_d = art_pkg::RS_DENY;
              state_d = S_DONE;
            end else if (sts_i.end_reach) begin
              res_d = art_pkg::RS_GRANT;
              state_d = S_DONE;
            end else begin
              cmd_o.advance = 1'b1;
              cmd_o.scan_start = 1'b1;
            end
          end else if (sts_i.ent_last) begin
            res_d = art_pkg::RS_DENY;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= art_pkg::RS_INVALID;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

// ===== hdl/art_dp.sv =====
module art_dp #(
  parameter int unsigned MAX_REGIONS = art_pkg::MaxRegions,
  parameter int unsigned PAGE_BYTES  = art_pkg::PageBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  art_pkg::in_t  in_data_i,
  input  logic [31:0]   user_base_i,
  input  logic [31:0]   user_top_i,
  input  art_pkg::cmd_t cmd_i,
  input  logic          out_ready_i,
  output art_pkg::sts_t sts_o,
  output logic          out_valid_o,
  output art_pkg::out_t out_data_o
);

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam logic [33:0] PMASK = 34'(PAGE_BYTES - 1);

  typedef struct packed {
    logic [31:0] r_start;
    logic [31:0] r_end;
    logic [3:0]  r_perm;
  } ent_t;

  ent_t              mem_q [MAX_REGIONS];
  ent_t              rd_q;
  logic [MAX_REGIONS-1:0] valid_q;
  logic [CW-1:0]     cnt_q, count_q;
  logic [IW-1:0]     ridx_q, free_idx_q;
  logic              pv_q, rvld_q, free_found_q;

  logic [1:0]  func_q;
  logic [3:0]  flags_q;
  logic        wr_q;
  logic [31:0] s_q, cur_q;
  logic [33:0] e_q;

  ent_t        cap_q;
  logic        out_valid_q;
  art_pkg::out_t out_q, res;

  logic [33:0] sum, s_ld, e_ld;
  logic        rd_en;

  assign sum  = {2'b0, in_data_i.addr} + {2'b0, in_data_i.length};
  assign s_ld = (in_data_i.func == art_pkg::FUNC_MAP) ?
                ({2'b0, in_data_i.addr} & ~PMASK) : {2'b0, in_data_i.addr};
  assign e_ld = (in_data_i.func == art_pkg::FUNC_MAP) ? ((sum + PMASK) & ~PMASK) : sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_data_i.func;
      flags_q <= in_data_i.flags;
      wr_q    <= in_data_i.write_access;
      s_q     <= s_ld[31:0];
      e_q     <= e_ld;
    end
    if (cmd_i.load) begin
      cur_q <= s_ld[31:0];
    end else if (cmd_i.advance) begin
      cur_q <= rd_q.r_end;
    end
    if (cmd_i.capture) begin
      cap_q <= rd_q;
    end
  end

  // region store
  assign rd_en = cmd_i.scan_run && !cmd_i.scan_start && (cnt_q < CW'(MAX_REGIONS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_q[free_idx_q] <= '{r_start: s_q, r_end: e_q[31:0], r_perm: flags_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem_q[cnt_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      ridx_q       <= '0;
      rvld_q       <= 1'b0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      valid_q      <= '0;
      count_q      <= '0;
    end else begin
      if (cmd_i.scan_start) begin
        cnt_q        <= '0;
        pv_q         <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        if (pv_q && !rvld_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= ridx_q;
        end
        if (rd_en) begin
          pv_q   <= 1'b1;
          ridx_q <= cnt_q[IW-1:0];
          rvld_q <= valid_q[cnt_q[IW-1:0]];
          cnt_q  <= cnt_q + CW'(1);
        end else begin
          pv_q <= 1'b0;
        end
      end
      if (cmd_i.commit) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q <= count_q + CW'(1);
      end
    end
  end

  // per-entry evaluation
  logic [32:0] guard_top;
  assign guard_top = {1'b0, rd_q.r_start} + 33'(PAGE_BYTES);

  always_comb begin
    sts_o.func      = func_q;
    sts_o.win_ok    = ({2'b0, user_base_i} <= {2'b0, s_q}) && ({2'b0, s_q} < e_q) &&
                      (e_q <= {2'b0, user_top_i});
    sts_o.ent_v     = pv_q;
    sts_o.ent_last  = (ridx_q == IW'(MAX_REGIONS - 1));
    sts_o.hit       = rvld_q && (rd_q.r_start <= cur_q) && (cur_q < rd_q.r_end);
    sts_o.ovl       = rvld_q && ({2'b0, rd_q.r_start} < e_q) && (s_q < rd_q.r_end);
    sts_o.perm_ok   = wr_q ? (rd_q.r_perm[1] &&
                              !(rd_q.r_perm[3] && ({1'b0, cur_q} < guard_top)))
                           : rd_q.r_perm[0];
    sts_o.end_reach = ({2'b0, rd_q.r_end} >= e_q);
    sts_o.full      = (count_q >= CW'(MAX_REGIONS)) || !free_found_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // result assembly
  always_comb begin
    res = '0;
    case (cmd_i.res_sel)
      art_pkg::RS_INVALID: res.status = art_pkg::ST_INVALID;
      art_pkg::RS_FULL:    res.status = art_pkg::ST_FULL;
      art_pkg::RS_MAPPED: begin
        res.status       = art_pkg::ST_OK;
        res.region_start = s_q;
        res.region_end   = e_q[31:0];
        res.region_flags = flags_q;
      end
      art_pkg::RS_FOUND: begin
        res.found        = 1'b1;
        res.region_start = cap_q.r_start;
        res.region_end   = cap_q.r_end;
        res.region_flags = cap_q.r_perm;
      end
      art_pkg::RS_GRANT:   res.access_ok = 1'b1;
      default:             res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/address_region_table_unit.sv =====
// map scans the table for overlap and commits after the last entry; find stops at the first hit
// check rescans the table once per region crossed
// map or check outside the user window, and the unused selector, answer without a table scan
// one item in flight; the next input transfer can come in the cycle after the result is loaded
// a finished result waits in the output register while the next item is taken
// reset clears valid bits, region count and control; user_base 0x00200000, user_top 0x80000000
module address_region_table_unit #(
  parameter int unsigned MAX_REGIONS = art_pkg::MaxRegions,
  parameter int unsigned PAGE_BYTES  = art_pkg::PageBytes
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  art_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output art_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [31:0]   user_base_q, user_top_q;
  art_pkg::cmd_t cmd;
  art_pkg::sts_t sts;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_base_q <= 32'h0020_0000;
      user_top_q  <= 32'h8000_0000;
    end else if (cfg_wr) begin
      if (paddr[2] == art_pkg::REG_USER_BASE) begin
        user_base_q <= pwdata;
      end else begin
        user_top_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == art_pkg::REG_USER_TOP) ? user_top_q : user_base_q;

  art_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  art_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .user_base_i (user_base_q),
    .user_top_i  (user_top_q),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/art_checker.sv =====
`include "assert_macros.svh"

module art_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input art_pkg::out_t out_data_o
);

  logic res_found, res_grant, res_fail, res_wait;
  logic status_ok, fail_clear, grant_alone;

  assign res_found   = out_valid_o && out_data_o.found;
  assign res_grant   = out_valid_o && out_data_o.access_ok;
  assign res_fail    = out_valid_o && (out_data_o.status != art_pkg::ST_OK);
  assign res_wait    = out_valid_o && !out_ready_i;
  assign status_ok   = (out_data_o.status == art_pkg::ST_OK);
  assign fail_clear  = (out_data_o.region_end == 32'd0) && !out_data_o.access_ok;
  assign grant_alone = !out_data_o.found && status_ok;

  `ART_ASSERT_NXT(a_out_hold, res_wait, out_valid_o && $stable(out_data_o))
  `ART_ASSERT_IMP(a_found_ok, res_found, status_ok)
  `ART_ASSERT_IMP(a_access_alone, res_grant, grant_alone)
  `ART_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)
  `ART_ASSERT_IMP(a_fail_empty, res_fail, fail_clear)

endmodule

bind address_region_table_unit art_checker u_art_checker (.*);
